>>> rtl/core/wrfp_pkg.sv
// Weather report field parser: shared types and constants.
// Used by the front, the queue and the back end.
package wrfp_pkg;

  // Classified character, as handed from the front to the back end
  typedef struct packed {
    logic       is_last;
    logic       is_digit;
    logic [3:0] digit;
    logic       is_ws;
    logic       is_plus;
    logic       is_minus;
    logic       is_zero;
    logic       is_bang;
    logic       is_under;
    logic [6:0] term_hit;
  } cls_t;

  // Report status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOT_WX  = 2'd1;
  localparam logic [1:0] ST_NO_MARK = 2'd2;
  localparam logic [1:0] ST_TRUNC   = 2'd3;

  // Field indexes, in report order; pressure comes after the seven fields
  localparam logic [2:0] FK_DIR   = 3'd0;
  localparam logic [2:0] FK_SPEED = 3'd1;
  localparam logic [2:0] FK_GUST  = 3'd2;
  localparam logic [2:0] FK_TEMP  = 3'd3;
  localparam logic [2:0] FK_RAIN1 = 3'd4;
  localparam logic [2:0] FK_RAIN2 = 3'd5;
  localparam logic [2:0] FK_RAIN3 = 3'd6;
  localparam logic [2:0] FK_PRESS = 3'd7;

  // Characters
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam int QUEUE_DEPTH = 4;

  localparam int          ACC_W   = 17;
  localparam logic [16:0] ACC_MAX = 17'd99999;

  // Reciprocals: floor(x / 9) = (x * K9) >> 19, floor(x / 10) = (x * K10) >> 20
  localparam logic [16:0] K9  = 17'd58255;
  localparam logic [16:0] K10 = 17'd104858;

endpackage

>>> rtl/core/wrfp_if.sv
// Weather report field parser: input and result channel interfaces.
// Depends on nothing; payload widths follow the report fields.
interface wrfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_last;

  modport source (output valid, data_byte, is_last, input ready);
  modport sink   (input valid, data_byte, is_last, output ready);
endinterface

interface wrfp_out_if;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [9:0]        wind_dir_deg;
  logic [15:0]       wind_speed_cms;
  logic [15:0]       wind_gust_cms;
  logic signed [13:0] temp_tenths_c;
  logic [9:0]        rain_last_hour;
  logic [9:0]        rain_last_day;
  logic [9:0]        rain_since_midnight;
  logic [13:0]       pressure_hpa;

  modport source (output valid, status, wind_dir_deg, wind_speed_cms, wind_gust_cms,
                  temp_tenths_c, rain_last_hour, rain_last_day, rain_since_midnight,
                  pressure_hpa, input ready);
  modport sink   (input valid, status, wind_dir_deg, wind_speed_cms, wind_gust_cms,
                  temp_tenths_c, rain_last_hour, rain_last_day, rain_since_midnight,
                  pressure_hpa, output ready);
endinterface

>>> rtl/core/wrfp_front.sv
// Weather report field parser front: accepts report bytes and classifies them.
// Depends on wrfp_pkg and wrfp_in_if; feeds the classified item to the queue.
module wrfp_front (
  input  logic          clk,
  input  logic          rst_n,
  wrfp_in_if.sink       in_ch,
  output logic          push_valid,
  input  logic          push_ready,
  output wrfp_pkg::cls_t push_item
);

  localparam logic [7:0] TERMS [7] = '{8'h2F, 8'h67, 8'h74, 8'h72, 8'h70, 8'h50, 8'h62};

  logic           f_valid_r;
  wrfp_pkg::cls_t f_item_r;
  wrfp_pkg::cls_t cls_nxt;
  logic           accept;

  assign in_ch.ready = !f_valid_r || push_ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign push_valid  = f_valid_r;
  assign push_item   = f_item_r;

  always_comb begin
    logic [7:0] c;
    c = in_ch.data_byte;
    cls_nxt.is_last  = in_ch.is_last;
    cls_nxt.is_digit = (c >= wrfp_pkg::CH_ZERO) && (c <= wrfp_pkg::CH_NINE);
    cls_nxt.digit    = 4'(c - wrfp_pkg::CH_ZERO);
    cls_nxt.is_ws    = (c == wrfp_pkg::CH_SPACE) || ((c >= 8'd9) && (c <= 8'd13));
    cls_nxt.is_plus  = (c == wrfp_pkg::CH_PLUS);
    cls_nxt.is_minus = (c == wrfp_pkg::CH_MINUS);
    cls_nxt.is_zero  = (c == 8'd0);
    cls_nxt.is_bang  = (c == wrfp_pkg::CH_BANG);
    cls_nxt.is_under = (c == wrfp_pkg::CH_UNDER);
    for (int i = 0; i < 7; i++) begin
      cls_nxt.term_hit[i] = (c == TERMS[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (accept) begin
      f_valid_r <= 1'b1;
    end else if (push_ready) begin
      f_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_item_r <= cls_nxt;
    end
  end

endmodule

>>> rtl/core/wrfp_queue.sv
// Weather report field parser queue: short FIFO of classified characters.
// Depends on wrfp_pkg; sits between the front and the back end.
module wrfp_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  wrfp_pkg::cls_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output wrfp_pkg::cls_t pop_item
);

  localparam int PTR_W = $clog2(wrfp_pkg::QUEUE_DEPTH);

  wrfp_pkg::cls_t   mem [wrfp_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W:0]   count_r;
  logic             push;
  logic             pop;

  assign push_ready = (count_r != (PTR_W+1)'(wrfp_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (PTR_W+1)'(wrfp_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");

endmodule

>>> rtl/core/wrfp_back.sv
// Weather report field parser back end: parse state, field conversion, held values
// and the result register. Depends on wrfp_pkg and wrfp_out_if.
module wrfp_back #(
  parameter int FIELD_CHARS    = 8,
  parameter int PRESSURE_CHARS = 5
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  wrfp_pkg::cls_t pop_item,
  wrfp_out_if.source     out_ch
);

  localparam int CNT_MAXV = (FIELD_CHARS > PRESSURE_CHARS) ? FIELD_CHARS : PRESSURE_CHARS;
  localparam int CNT_W    = $clog2(CNT_MAXV + 1);
  localparam logic [CNT_W-1:0] FC_LIM = CNT_W'(FIELD_CHARS);
  localparam logic [CNT_W-1:0] PC_LIM = CNT_W'(PRESSURE_CHARS);
  localparam int AW = wrfp_pkg::ACC_W;

  typedef enum logic [2:0] {PH_FIRST, PH_SKIP, PH_FIELD, PH_PRESS, PH_HALT} phase_t;

  // parser state
  phase_t           ph_r, ph_nxt;
  logic [2:0]       fk_r, fk_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0]    acc_r, acc_nxt;
  logic             minus_r, minus_nxt;
  logic             ended_r, ended_nxt;
  logic             started_r, started_nxt;
  logic [1:0]       status_r, status_nxt;

  // result of taking one character into the current field
  logic [CNT_W-1:0] tk_cnt;
  logic [AW-1:0]    tk_acc;
  logic             tk_minus, tk_ended, tk_started;
  logic [20:0]      acc_wide;

  // stage A outputs
  logic             cm, em;
  logic [2:0]       cm_k;
  logic [AW-1:0]    cm_acc;
  logic             cm_minus;
  logic [1:0]       em_status;

  // stage 1 registers
  logic             p1_valid_r, p1_commit_r, p1_emit_r, p1_minus_r;
  logic [2:0]       p1_k_r;
  logic [AW-1:0]    p1_acc_r;
  logic [1:0]       p1_status_r;

  // stage 2 registers
  logic             p2_valid_r, p2_commit_r, p2_emit_r, p2_neg_r;
  logic [2:0]       p2_k_r;
  logic [9:0]       p2_small_r;
  logic [15:0]      p2_spd_r;
  logic [AW-1:0]    p2_x_r;
  logic [1:0]       p2_status_r;

  // prepare stage
  logic [9:0]       b_small, b_vp, b_tabs;
  logic [15:0]      b_spd, b_tx;
  logic             b_tneg;
  logic [AW-1:0]    b_x;
  logic             b_neg;

  // convert stage
  logic [16:0]       mul_k;
  logic [33:0]       prod;
  logic [13:0]       q14;
  logic [9:0]        held_dir_r, held_dir_nxt;
  logic [15:0]       held_spd_r, held_spd_nxt;
  logic [15:0]       held_gust_r, held_gust_nxt;
  logic signed [13:0] held_temp_r, held_temp_nxt;
  logic [9:0]        held_r1_r, held_r1_nxt;
  logic [9:0]        held_r2_r, held_r2_nxt;
  logic [9:0]        held_r3_r, held_r3_nxt;
  logic [13:0]       held_press_r, held_press_nxt;

  // result register
  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic [9:0]        out_dir_r, out_r1_r, out_r2_r, out_r3_r;
  logic [15:0]       out_spd_r, out_gust_r;
  logic signed [13:0] out_temp_r;
  logic [13:0]       out_press_r;

  logic hold, adv, pop, load_out;

  assign hold      = p2_valid_r && p2_emit_r && out_valid_r && !out_ch.ready;
  assign adv       = !hold;
  assign pop_ready = adv;
  assign pop       = pop_valid && adv;
  assign load_out  = adv && p2_valid_r && p2_emit_r;

  function automatic logic [1:0] end_status(phase_t ph, logic [1:0] st);
    logic [1:0] r;
    case (ph)
      PH_FIRST: r = wrfp_pkg::ST_NOT_WX;
      PH_SKIP:  r = wrfp_pkg::ST_NO_MARK;
      PH_PRESS: r = wrfp_pkg::ST_OK;
      PH_FIELD: r = wrfp_pkg::ST_TRUNC;
      default:  r = st;
    endcase
    return r;
  endfunction

  // take one character into the field: skip blanks, one sign, then digits
  always_comb begin
    tk_cnt     = cnt_r;
    tk_acc     = acc_r;
    tk_minus   = minus_r;
    tk_ended   = ended_r;
    tk_started = started_r;
    acc_wide   = 21'({acc_r, 3'b000}) + 21'({acc_r, 1'b0}) + 21'(pop_item.digit);
    if (cnt_r < FC_LIM) begin
      tk_cnt = cnt_r + 1'b1;
      if (!ended_r) begin
        if (!started_r && pop_item.is_ws) begin
          tk_cnt = cnt_r + 1'b1;
        end else if (!started_r && (pop_item.is_plus || pop_item.is_minus)) begin
          tk_started = 1'b1;
          tk_minus   = pop_item.is_minus;
        end else if (pop_item.is_digit) begin
          tk_started = 1'b1;
          tk_acc     = (acc_wide > 21'(wrfp_pkg::ACC_MAX)) ? wrfp_pkg::ACC_MAX
                                                          : acc_wide[AW-1:0];
        end else begin
          tk_ended = 1'b1;
        end
      end
    end
  end

  // stage A: parse step
  always_comb begin
    ph_nxt      = ph_r;
    fk_nxt      = fk_r;
    cnt_nxt     = cnt_r;
    acc_nxt     = acc_r;
    minus_nxt   = minus_r;
    ended_nxt   = ended_r;
    started_nxt = started_r;
    status_nxt  = status_r;
    cm          = 1'b0;
    cm_k        = fk_r;
    cm_acc      = acc_r;
    cm_minus    = minus_r;
    em          = 1'b0;
    em_status   = status_r;
    if (ph_r != PH_HALT) begin
      if (ph_r == PH_FIRST) begin
        if (!pop_item.is_bang) begin
          status_nxt = wrfp_pkg::ST_NOT_WX;
          ph_nxt     = PH_HALT;
        end else begin
          ph_nxt = PH_SKIP;
        end
      end else if (pop_item.is_zero) begin
        // a NUL ends the text here
        status_nxt = end_status(ph_r, status_r);
        ph_nxt     = PH_HALT;
      end else begin
        case (ph_r)
          PH_SKIP: begin
            if (pop_item.is_under) begin
              ph_nxt      = PH_FIELD;
              fk_nxt      = wrfp_pkg::FK_DIR;
              cnt_nxt     = '0;
              acc_nxt     = '0;
              minus_nxt   = 1'b0;
              ended_nxt   = 1'b0;
              started_nxt = 1'b0;
            end
          end
          PH_PRESS: begin
            cnt_nxt     = tk_cnt;
            acc_nxt     = tk_acc;
            minus_nxt   = tk_minus;
            ended_nxt   = tk_ended;
            started_nxt = tk_started;
            if (tk_cnt >= PC_LIM) begin
              cm         = 1'b1;
              cm_k       = wrfp_pkg::FK_PRESS;
              cm_acc     = tk_acc;
              cm_minus   = tk_minus;
              status_nxt = wrfp_pkg::ST_OK;
              ph_nxt     = PH_HALT;
            end
          end
          PH_FIELD: begin
            // the first character of a field never terminates it
            if ((cnt_r != '0) && pop_item.term_hit[fk_r]) begin
              cm = 1'b1;
              if (fk_r == wrfp_pkg::FK_RAIN3) begin
                ph_nxt = PH_PRESS;
              end else begin
                fk_nxt = fk_r + 3'd1;
              end
              cnt_nxt     = '0;
              acc_nxt     = '0;
              minus_nxt   = 1'b0;
              ended_nxt   = 1'b0;
              started_nxt = 1'b0;
            end else begin
              cnt_nxt     = tk_cnt;
              acc_nxt     = tk_acc;
              minus_nxt   = tk_minus;
              ended_nxt   = tk_ended;
              started_nxt = tk_started;
            end
          end
          default: begin
            ph_nxt = ph_r;
          end
        endcase
      end
    end
    if (pop_item.is_last) begin
      em          = 1'b1;
      em_status   = end_status(ph_nxt, status_nxt);
      ph_nxt      = PH_FIRST;
      status_nxt  = wrfp_pkg::ST_OK;
      cnt_nxt     = '0;
      acc_nxt     = '0;
      minus_nxt   = 1'b0;
      ended_nxt   = 1'b0;
      started_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r        <= PH_FIRST;
      fk_r        <= wrfp_pkg::FK_DIR;
      cnt_r       <= '0;
      acc_r       <= '0;
      minus_r     <= 1'b0;
      ended_r     <= 1'b0;
      started_r   <= 1'b0;
      status_r    <= wrfp_pkg::ST_OK;
      p1_valid_r  <= 1'b0;
      p1_commit_r <= 1'b0;
      p1_emit_r   <= 1'b0;
      p1_k_r      <= wrfp_pkg::FK_DIR;
      p1_acc_r    <= '0;
      p1_minus_r  <= 1'b0;
      p1_status_r <= wrfp_pkg::ST_OK;
    end else if (adv) begin
      if (pop) begin
        ph_r      <= ph_nxt;
        fk_r      <= fk_nxt;
        cnt_r     <= cnt_nxt;
        acc_r     <= acc_nxt;
        minus_r   <= minus_nxt;
        ended_r   <= ended_nxt;
        started_r <= started_nxt;
        status_r  <= status_nxt;
      end
      p1_valid_r  <= pop && (cm || em);
      p1_commit_r <= cm;
      p1_emit_r   <= em;
      p1_k_r      <= cm_k;
      p1_acc_r    <= cm_acc;
      p1_minus_r  <= cm_minus;
      p1_status_r <= em_status;
    end
  end

  // prepare: clamp and scale ahead of the shared divide-by-constant
  always_comb begin
    b_small = p1_minus_r ? 10'd0
            : ((p1_acc_r > AW'(999)) ? 10'd999 : p1_acc_r[9:0]);
    b_spd   = 16'({b_small, 5'b0}) + 16'({b_small, 3'b0}) + 16'({b_small, 2'b0});
    b_vp    = (p1_acc_r > AW'(999)) ? 10'd999 : p1_acc_r[9:0];
    if (p1_minus_r) begin
      b_tabs = ((p1_acc_r > AW'(99)) ? 10'd99 : p1_acc_r[9:0]) + 10'd32;
      b_tneg = 1'b1;
    end else if (b_vp >= 10'd32) begin
      b_tabs = b_vp - 10'd32;
      b_tneg = 1'b0;
    end else begin
      b_tabs = 10'd32 - b_vp;
      b_tneg = 1'b1;
    end
    // |F - 32| * 50 + 4, ready for the rounded divide by nine
    b_tx = 16'({b_tabs, 5'b0}) + 16'({b_tabs, 4'b0}) + 16'({b_tabs, 1'b0}) + 16'd4;
    if (p1_k_r == wrfp_pkg::FK_PRESS) begin
      b_x   = p1_acc_r;
      b_neg = p1_minus_r;
    end else begin
      b_x   = AW'(b_tx);
      b_neg = b_tneg;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_valid_r <= 1'b0;
    end else if (adv) begin
      p2_valid_r <= p1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p2_commit_r <= p1_commit_r;
      p2_emit_r   <= p1_emit_r;
      p2_k_r      <= p1_k_r;
      p2_small_r  <= b_small;
      p2_spd_r    <= b_spd;
      p2_x_r      <= b_x;
      p2_neg_r    <= b_neg;
      p2_status_r <= p1_status_r;
    end
  end

  // convert and store
  assign mul_k = (p2_k_r == wrfp_pkg::FK_PRESS) ? wrfp_pkg::K10 : wrfp_pkg::K9;
  assign prod  = 34'(p2_x_r) * 34'(mul_k);
  assign q14   = (p2_k_r == wrfp_pkg::FK_PRESS) ? prod[33:20] : prod[32:19];

  always_comb begin
    held_dir_nxt   = held_dir_r;
    held_spd_nxt   = held_spd_r;
    held_gust_nxt  = held_gust_r;
    held_temp_nxt  = held_temp_r;
    held_r1_nxt    = held_r1_r;
    held_r2_nxt    = held_r2_r;
    held_r3_nxt    = held_r3_r;
    held_press_nxt = held_press_r;
    if (p2_valid_r && p2_commit_r) begin
      case (p2_k_r)
        wrfp_pkg::FK_DIR:   held_dir_nxt   = p2_small_r;
        wrfp_pkg::FK_SPEED: held_spd_nxt   = p2_spd_r;
        wrfp_pkg::FK_GUST:  held_gust_nxt  = p2_spd_r;
        wrfp_pkg::FK_TEMP:  held_temp_nxt  = p2_neg_r ? -$signed(q14) : $signed(q14);
        wrfp_pkg::FK_RAIN1: held_r1_nxt    = p2_small_r;
        wrfp_pkg::FK_RAIN2: held_r2_nxt    = p2_small_r;
        wrfp_pkg::FK_RAIN3: held_r3_nxt    = p2_small_r;
        wrfp_pkg::FK_PRESS: held_press_nxt = p2_neg_r ? 14'd0 : q14;
        default:            held_dir_nxt   = held_dir_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_dir_r   <= '0;
      held_spd_r   <= '0;
      held_gust_r  <= '0;
      held_temp_r  <= '0;
      held_r1_r    <= '0;
      held_r2_r    <= '0;
      held_r3_r    <= '0;
      held_press_r <= '0;
    end else if (adv) begin
      held_dir_r   <= held_dir_nxt;
      held_spd_r   <= held_spd_nxt;
      held_gust_r  <= held_gust_nxt;
      held_temp_r  <= held_temp_nxt;
      held_r1_r    <= held_r1_nxt;
      held_r2_r    <= held_r2_nxt;
      held_r3_r    <= held_r3_nxt;
      held_press_r <= held_press_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status_r <= p2_status_r;
      out_dir_r    <= held_dir_nxt;
      out_spd_r    <= held_spd_nxt;
      out_gust_r   <= held_gust_nxt;
      out_temp_r   <= held_temp_nxt;
      out_r1_r     <= held_r1_nxt;
      out_r2_r     <= held_r2_nxt;
      out_r3_r     <= held_r3_nxt;
      out_press_r  <= held_press_nxt;
    end
  end

  assign out_ch.valid               = out_valid_r;
  assign out_ch.status              = out_status_r;
  assign out_ch.wind_dir_deg        = out_dir_r;
  assign out_ch.wind_speed_cms      = out_spd_r;
  assign out_ch.wind_gust_cms       = out_gust_r;
  assign out_ch.temp_tenths_c       = out_temp_r;
  assign out_ch.rain_last_hour      = out_r1_r;
  assign out_ch.rain_last_day       = out_r2_r;
  assign out_ch.rain_since_midnight = out_r3_r;
  assign out_ch.pressure_hpa        = out_press_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CNT_MAXV))
    else $error("field character count out of range");

  a_acc_sat: assert property (@(posedge clk) disable iff (!rst_n)
    acc_r <= wrfp_pkg::ACC_MAX)
    else $error("digit accumulator above saturation limit");

  a_last_rearms: assert property (@(posedge clk) disable iff (!rst_n)
    pop && pop_item.is_last |=> ph_r == PH_FIRST && cnt_r == '0 && status_r == wrfp_pkg::ST_OK)
    else $error("parser not rearmed after last byte");

  a_neg_press: assert property (@(posedge clk) disable iff (!rst_n)
    adv && p2_valid_r && p2_commit_r && p2_k_r == wrfp_pkg::FK_PRESS && p2_neg_r
    |=> held_press_r == '0)
    else $error("negative pressure not stored as zero");

endmodule

>>> rtl/core/weather_report_field_parser_top.sv
// Weather report field parser, top level.
// Channel bytes come in on in_ch; one result per report leaves on out_ch. Every
// byte is accepted when in_ch.valid and in_ch.ready are high at a rising clk edge;
// is_last marks the final byte of a report. A result is taken when out_ch.valid
// and out_ch.ready are both high, and carries the status and all held field values.
// Throughput: one byte per cycle, sustained while the back end does not hold, set by
// the parse step (one multiply-by-ten and saturate on the digit accumulator).
// A report's last byte goes from the front register through the queue, parse and
// prepare; convert then loads the report's result into the result register.
// A 4-entry queue decouples the front from the back end. While out_ch.ready is
// low with a result waiting, the back end keeps parsing until the next result
// reaches the convert stage, then holds; the queue fills and in_ch.ready drops.
// Reset (rst_n low at a clock edge) empties the pipeline and queue, rearms the
// parser to expect the first byte of a report and clears all held values to zero.
// Depends on wrfp_pkg, wrfp_if, wrfp_front, wrfp_queue and wrfp_back.
module weather_report_field_parser_top #(
  parameter int FIELD_CHARS    = 8,
  parameter int PRESSURE_CHARS = 5
) (
  input  logic       clk,
  input  logic       rst_n,
  wrfp_in_if.sink    in_ch,
  wrfp_out_if.source out_ch
);

  logic           push_valid;
  logic           push_ready;
  wrfp_pkg::cls_t push_item;
  logic           pop_valid;
  logic           pop_ready;
  wrfp_pkg::cls_t pop_item;

  wrfp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  wrfp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  wrfp_back #(
    .FIELD_CHARS    (FIELD_CHARS),
    .PRESSURE_CHARS (PRESSURE_CHARS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .out_ch    (out_ch)
  );

endmodule
